[hdl/pft_pkg.sv]
// pft_pkg: shared types, widths and codes for the prefix filter table
// no dependencies; used by every module under hdl
package pft_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = 32;
   localparam int LEN_W = 6;
   localparam int IDX_W = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_OUT_W = 7;
   localparam int MODE_W = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 80;
   localparam int MAX_LEN = 32;

   // item kinds
   localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CHECK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PREFIX = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_COVERS = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 3'd4;

   // one table entry as held by a cell
   typedef struct packed {
      logic              valid;
      logic              allow;
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [31:0]       hits;
      logic [ADDR_W-1:0] last_blocked;
   } entry_type;

   // per-cell update strobes
   typedef struct packed {
      logic shift;
      logic clear;
      logic hit;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]        pad;
      logic [IDX_W-1:0]  entry_index;
      logic              allow_flag;
      logic [LEN_W-1:0]  prefix_len;
      logic [ADDR_W-1:0] address;
   } req_data_type;

   typedef struct packed {
      logic [3:0]             pad;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [ADDR_W-1:0]      last_blocked_address;
      logic [31:0]            hit_count;
      logic                   matched;
      logic                   blocked;
      logic [STATUS_W-1:0]    status;
   } rsp_data_type;

endpackage

[hdl/prefix_filter_table.sv]
// prefix_filter_table: top level, chain of entry cells plus item sequencer
// depends on pft_pkg, pft_cell, pft_pick
//
// usage:
//   req channel carries one transaction per item; req_tuser holds the mode
//   (add, check, clear, read), req_tdata the address, prefix length, allow
//   flag and entry index. rsp channel returns exactly one transaction per item
//   with status, match flags, the read counters and the entry count.
//   csr_write_en / csr_write_data load the protected address; write it only
//   while no item is in flight.
// timing:
//   the accepting edge latches the item and enters the eval state, which
//   registers the match vector of all cells compared in parallel and the
//   status; the commit state then picks the first match, updates the cells
//   and loads the result once rsp is free. the next item is accepted only
//   after the commit, back in the idle state, so one item is in flight at a time.
// stalls:
//   the result sits in an output register; a new item is taken while it
//   waits, but the commit step holds (table unchanged) until rsp is free.
// reset:
//   synchronous; empties the table, zeroes the protected address and drops
//   any pending result.
module prefix_filter_table (
   input  logic                              clock,
   input  logic                              reset,
   // slave side
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // address[31:0], prefix_len[37:32], allow_flag[38], entry_index[44:39], zero pad
   input  logic [pft_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [pft_pkg::MODE_W-1:0]        req_tuser,
   // master side
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], blocked[3], matched[4], hit_count[36:5],
   // last_blocked_address[68:37], entry_count[75:69], zero pad
   output logic [pft_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                              csr_write_en,
   input  logic [pft_pkg::ADDR_W-1:0]        csr_write_data
);

   localparam int DEPTH = pft_pkg::TABLE_DEPTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [pft_pkg::MODE_W-1:0]       mode_ff, mode_in;
   pft_pkg::req_data_type            op_ff, op_in;
   logic [pft_pkg::ADDR_W-1:0]       prot_ff, prot_in;
   logic [pft_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [DEPTH-1:0]                 match_ff, match_in;
   logic [pft_pkg::STATUS_W-1:0]     status_ff, status_in;
   logic [31:0]                      rd_hits_ff, rd_hits_in;
   logic [pft_pkg::ADDR_W-1:0]       rd_last_ff, rd_last_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pft_pkg::rsp_data_type            rsp_data_ff, rsp_data_in;

   // cell chain
   pft_pkg::entry_type               cell_entry [DEPTH];
   pft_pkg::cell_ctl_type            cell_ctl [DEPTH];
   logic [DEPTH-1:0]                 cell_match;
   logic [DEPTH-1:0]                 cell_allow;
   logic [DEPTH-1:0]                 first_vec;
   pft_pkg::entry_type               new_entry;

   // add checks and read gather
   logic [pft_pkg::ADDR_W-1:0]       new_mask;
   logic                             bad_len;
   logic                             covers_prot;
   logic                             table_full;
   logic                             read_ok;
   logic [31:0]                      sel_hits;
   logic [pft_pkg::ADDR_W-1:0]       sel_last;

   // commit strobes
   logic                             out_free;
   logic                             commit;
   logic                             do_add;
   logic                             do_clear;
   logic                             do_hit;
   logic                             any_match;
   logic                             first_allow;

   // mask has len leading ones; len outside 1..32 is rejected anyway
   assign new_mask = ~(32'hFFFF_FFFF >> op_ff.prefix_len);
   assign bad_len = (op_ff.prefix_len == '0) ||
                    (op_ff.prefix_len > pft_pkg::LEN_W'(pft_pkg::MAX_LEN));
   assign covers_prot = ((op_ff.address ^ prot_ff) & new_mask) == '0;
   assign table_full = (count_ff == pft_pkg::CNT_W'(DEPTH));
   assign read_ok = int'(op_ff.entry_index) < int'(count_ff);

   always_comb begin
      new_entry = '0;
      new_entry.valid = 1'b1;
      new_entry.allow = op_ff.allow_flag;
      new_entry.prefix = op_ff.address & new_mask;
      new_entry.mask = new_mask;
   end

   // one-hot read select, or-combined across the row
   always_comb begin
      sel_hits = '0;
      sel_last = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (int'(op_ff.entry_index) == i) begin
            sel_hits = sel_hits | cell_entry[i].hits;
            sel_last = sel_last | cell_entry[i].last_blocked;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit = (state_ff == ST_COMMIT) && out_free;
   assign do_add = commit && (mode_ff == pft_pkg::MODE_ADD) &&
                   (status_ff == pft_pkg::STATUS_OK);
   assign do_clear = commit && (mode_ff == pft_pkg::MODE_CLEAR);
   assign do_hit = commit && (mode_ff == pft_pkg::MODE_CHECK);

   pft_pick u_pick (
      .match_vec (match_ff),
      .first_vec (first_vec)
   );

   assign any_match = |match_ff;
   assign first_allow = |(first_vec & cell_allow);

   // row of cells: cell 0 takes the new entry, each other cell its left neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign cell_ctl[g] = '{shift: do_add, clear: do_clear, hit: do_hit && first_vec[g]};
      assign cell_allow[g] = cell_entry[g].allow;
      if (g == 0) begin : g_head
         pft_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl[g]),
            .prev_entry (new_entry),
            .check_addr (op_ff.address),
            .entry      (cell_entry[g]),
            .match      (cell_match[g])
         );
      end else begin : g_body
         pft_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (cell_ctl[g]),
            .prev_entry (cell_entry[g-1]),
            .check_addr (op_ff.address),
            .entry      (cell_entry[g]),
            .match      (cell_match[g])
         );
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      op_in = op_ff;
      prot_in = prot_ff;
      count_in = count_ff;
      match_in = match_ff;
      status_in = status_ff;
      rd_hits_in = rd_hits_ff;
      rd_last_in = rd_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_write_en) begin
         prot_in = csr_write_data;
      end

      // result taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               op_in = pft_pkg::req_data_type'(req_tdata);
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            match_in = cell_match;
            rd_hits_in = '0;
            rd_last_in = '0;
            unique case (mode_ff)
               pft_pkg::MODE_ADD: begin
                  priority if (bad_len) begin
                     status_in = pft_pkg::STATUS_BAD_PREFIX;
                  end else if (covers_prot) begin
                     status_in = pft_pkg::STATUS_COVERS;
                  end else if (table_full) begin
                     status_in = pft_pkg::STATUS_FULL;
                  end else begin
                     status_in = pft_pkg::STATUS_OK;
                  end
               end
               pft_pkg::MODE_READ: begin
                  if (read_ok) begin
                     status_in = pft_pkg::STATUS_OK;
                     rd_hits_in = sel_hits;
                     rd_last_in = sel_last;
                  end else begin
                     status_in = pft_pkg::STATUS_BAD_INDEX;
                  end
               end
               default: begin
                  status_in = pft_pkg::STATUS_OK;
               end
            endcase
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               if (do_add) begin
                  count_in = count_ff + pft_pkg::CNT_W'(1);
               end else if (do_clear) begin
                  count_in = '0;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in.status = status_ff;
               rsp_data_in.matched = do_hit && any_match;
               rsp_data_in.blocked = do_hit && any_match && !first_allow;
               rsp_data_in.hit_count = rd_hits_ff;
               rsp_data_in.last_blocked_address = rd_last_ff;
               rsp_data_in.entry_count = pft_pkg::COUNT_OUT_W'(count_in);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      mode_ff <= mode_in;
      op_ff <= op_in;
      prot_ff <= prot_in;
      count_ff <= count_in;
      match_ff <= match_in;
      status_ff <= status_in;
      rd_hits_ff <= rd_hits_in;
      rd_last_ff <= rd_last_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         prot_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

[hdl/pft_cell.sv]
// pft_cell: one table entry with its match compare and counters
// depends on pft_pkg; chained by prefix_filter_table
module pft_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  pft_pkg::cell_ctl_type          ctl,
   input  pft_pkg::entry_type             prev_entry,
   input  logic [pft_pkg::ADDR_W-1:0]     check_addr,
   output pft_pkg::entry_type             entry,
   output logic                           match
);

   pft_pkg::entry_type entry_ff;
   pft_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.clear) begin
         entry_in.valid = 1'b0;
      end else if (ctl.shift) begin
         entry_in = prev_entry;
      end else if (ctl.hit) begin
         // saturating hit counter
         if (entry_ff.hits != '1) begin
            entry_in.hits = entry_ff.hits + 32'd1;
         end
         if (!entry_ff.allow) begin
            entry_in.last_blocked = check_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end
   end

   assign entry = entry_ff;
   assign match = entry_ff.valid && ((check_addr & entry_ff.mask) == entry_ff.prefix);

endmodule

[hdl/pft_pick.sv]
// pft_pick: isolates the lowest set match bit (first match in table order)
// depends on pft_pkg
module pft_pick (
   input  logic [pft_pkg::TABLE_DEPTH-1:0] match_vec,
   output logic [pft_pkg::TABLE_DEPTH-1:0] first_vec
);

   // two's complement trick: m & -m keeps only the lowest one
   assign first_vec = match_vec & (~match_vec + pft_pkg::TABLE_DEPTH'(1));

endmodule

[hdl/pft_checker.sv]
// pft_checker: port-level assertions for prefix_filter_table, bound to the top
// depends on pft_pkg and prefix_filter_table
module pft_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pft_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   pft_pkg::rsp_data_type rsp;
   assign rsp = pft_pkg::rsp_data_type'(rsp_tdata);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp transaction changed");

   // one item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // blocked only on a match
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp.blocked || rsp.matched)
      else $error("blocked without match");

   // entry count never beyond table depth
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> int'(rsp.entry_count) <= pft_pkg::TABLE_DEPTH)
      else $error("entry count beyond table depth");

   // counters only on a good read, match flags never on a bad status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status != pft_pkg::STATUS_OK) |->
         !rsp.matched && (rsp.hit_count == '0) && (rsp.last_blocked_address == '0))
      else $error("payload on rejected transaction");

endmodule

bind prefix_filter_table pft_checker u_pft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
